/* hw/rtl/clen_pkg.sv */
// ----------------------------------------------------------------------------
// clen_pkg
// Shared types, constants and helpers for the content-length deframer.
// ----------------------------------------------------------------------------
package clen_pkg;

	// width of the declared length and the body countdown
	localparam int LEN_W = 29;
	// width of the max_body_length register
	localparam int MAXLEN_W = 29;
	// width of the hunt counter and the max_hunt_bytes register
	localparam int HUNT_W = 21;
	// width of the configuration write data (widest register)
	localparam int CFG_W = (MAXLEN_W > HUNT_W) ? MAXLEN_W : HUNT_W;
	// common width for comparing the length against its limit
	localparam int CMP_W = (LEN_W > MAXLEN_W) ? LEN_W : MAXLEN_W;

	// header prefix "Content-Length: "
	localparam int HDR_LEN = 16;
	localparam int PFX_W = 5;

	localparam logic [MAXLEN_W-1:0] MAX_BODY_RESET = MAXLEN_W'(268435456);
	localparam logic [HUNT_W-1:0] MAX_HUNT_RESET = HUNT_W'(65536);

	// byte codes
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_C = 8'h43;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_MAX_BODY = 1'b0,
		REG_MAX_HUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_HUNT     = 4'd0,
		PH_LEAD     = 4'd1,
		PH_LEAD_CR  = 4'd2,
		PH_SIGNED   = 4'd3,
		PH_DIGITS   = 4'd4,
		PH_TAIL     = 4'd5,
		PH_TAIL_CR  = 4'd6,
		PH_BLANK_CR = 4'd7,
		PH_BLANK_LF = 4'd8,
		PH_BODY     = 4'd9,
		PH_TRAIL    = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BODY  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_HUNT     = 3'd1,
		ERR_LENGTH   = 3'd2,
		ERR_NO_BLANK = 3'd3,
		ERR_NO_LF    = 3'd4
	} err_t;

	// one result word from the parser
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data;
		err_t       code;
	} result_t;

	// byte of the header prefix at a position
	function automatic logic [7:0] hdr_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:  c = 8'h43; // C
			4'd1:  c = 8'h6F; // o
			4'd2:  c = 8'h6E; // n
			4'd3:  c = 8'h74; // t
			4'd4:  c = 8'h65; // e
			4'd5:  c = 8'h6E; // n
			4'd6:  c = 8'h74; // t
			4'd7:  c = 8'h2D; // -
			4'd8:  c = 8'h4C; // L
			4'd9:  c = 8'h65; // e
			4'd10: c = 8'h6E; // n
			4'd11: c = 8'h67; // g
			4'd12: c = 8'h74; // t
			4'd13: c = 8'h68; // h
			4'd14: c = 8'h3A; // :
			default: c = 8'h20; // space
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/clen_in_stage.sv */
// ----------------------------------------------------------------------------
// clen_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module clen_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// hold off upstream while a word waits and cannot move on
	assign in_stall = valid_s1 && !advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

/* hw/rtl/clen_parser.sv */
// ----------------------------------------------------------------------------
// clen_parser
// Framing state machine: prefix hunt, length line, blank line, body count
// and trailing LF, plus the two limit registers.
// ----------------------------------------------------------------------------
module clen_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [0:0]                 cfg_index,
	input  logic [clen_pkg::CFG_W-1:0] cfg_data,
	input  logic                       step,
	input  logic [7:0]                 byte_s1,
	output clen_pkg::result_t          result
);

	localparam int SUM_W = clen_pkg::LEN_W + 4;

	// state
	clen_pkg::phase_t              phase_q, phase_d;
	logic [clen_pkg::PFX_W-1:0]    prefix_q, prefix_d;
	logic [clen_pkg::LEN_W-1:0]    acc_q, acc_d;
	logic                          too_big_q, too_big_d;
	logic                          neg_q, neg_d;
	logic                          seen_q, seen_d;
	logic [clen_pkg::LEN_W-1:0]    remain_q, remain_d;
	logic [clen_pkg::HUNT_W-1:0]   hunt_q, hunt_d;
	logic [clen_pkg::MAXLEN_W-1:0] max_body_q;
	logic [clen_pkg::HUNT_W-1:0]   max_hunt_q;

	// byte classes
	logic is_cr, is_lf, is_ws, is_digit, is_sign;
	assign is_cr    = (byte_s1 == clen_pkg::CH_CR);
	assign is_lf    = (byte_s1 == clen_pkg::CH_LF);
	assign is_ws    = (byte_s1 == clen_pkg::CH_SP) ||
	                  (byte_s1 >= clen_pkg::CH_TAB && byte_s1 <= clen_pkg::CH_CR);
	assign is_digit = (byte_s1 >= clen_pkg::CH_ZERO) && (byte_s1 <= clen_pkg::CH_NINE);
	assign is_sign  = (byte_s1 == clen_pkg::CH_PLUS) || (byte_s1 == clen_pkg::CH_MINUS);

	// accumulate one decimal digit, saturating
	logic [SUM_W-1:0]           acc_ext, acc_sum;
	logic                       acc_ovf;
	logic [clen_pkg::LEN_W-1:0] acc_digit;
	assign acc_ext   = SUM_W'(acc_q);
	assign acc_sum   = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(byte_s1[3:0]);
	assign acc_ovf   = |acc_sum[SUM_W-1:clen_pkg::LEN_W];
	assign acc_digit = acc_ovf ? '1 : acc_sum[clen_pkg::LEN_W-1:0];

	// length check at the end of the line
	logic len_bad;
	assign len_bad = !seen_q || too_big_q || (neg_q && (acc_q != '0)) ||
	                 (clen_pkg::CMP_W'(acc_q) > clen_pkg::CMP_W'(max_body_q));

	// prefix match and hunt counter
	logic                        pfx_hit, pfx_done, hunt_fail;
	logic [clen_pkg::PFX_W-1:0]  prefix_inc;
	logic [clen_pkg::HUNT_W-1:0] hunt_inc;
	assign pfx_hit    = (prefix_q < clen_pkg::PFX_W'(clen_pkg::HDR_LEN)) &&
	                    (byte_s1 == clen_pkg::hdr_char(prefix_q[3:0]));
	assign prefix_inc = prefix_q + 1'b1;
	assign pfx_done   = pfx_hit && (prefix_inc == clen_pkg::PFX_W'(clen_pkg::HDR_LEN));
	assign hunt_inc   = (hunt_q != '1) ? hunt_q + 1'b1 : hunt_q;
	assign hunt_fail  = !pfx_done && (hunt_inc > max_hunt_q);

	// body countdown
	logic [clen_pkg::LEN_W-1:0] remain_dec;
	assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;

	// number reader position
	logic leading, digits_ok;
	assign leading   = (phase_q == clen_pkg::PH_LEAD) || (phase_q == clen_pkg::PH_LEAD_CR);
	assign digits_ok = (phase_q == clen_pkg::PH_SIGNED) || (phase_q == clen_pkg::PH_DIGITS);

	// next state
	always_comb begin
		phase_d   = phase_q;
		prefix_d  = prefix_q;
		acc_d     = acc_q;
		too_big_d = too_big_q;
		neg_d     = neg_q;
		seen_d    = seen_q;
		remain_d  = remain_q;
		hunt_d    = hunt_q;
		unique case (phase_q)
			clen_pkg::PH_LEAD, clen_pkg::PH_LEAD_CR, clen_pkg::PH_SIGNED,
			clen_pkg::PH_DIGITS, clen_pkg::PH_TAIL, clen_pkg::PH_TAIL_CR: begin
				if ((phase_q == clen_pkg::PH_LEAD_CR || phase_q == clen_pkg::PH_TAIL_CR)
				    && is_lf) begin
					if (len_bad) begin
						phase_d   = clen_pkg::PH_HUNT;
						prefix_d  = '0;
						hunt_d    = '0;
						acc_d     = '0;
						too_big_d = 1'b0;
						neg_d     = 1'b0;
						seen_d    = 1'b0;
						remain_d  = '0;
					end else begin
						remain_d = acc_q;
						phase_d  = clen_pkg::PH_BLANK_CR;
					end
				end else if (leading) begin
					priority if (is_cr) begin
						phase_d = clen_pkg::PH_LEAD_CR;
					end else if (is_ws) begin
						phase_d = clen_pkg::PH_LEAD;
					end else if (is_sign) begin
						neg_d   = (byte_s1 == clen_pkg::CH_MINUS);
						phase_d = clen_pkg::PH_SIGNED;
					end else if (is_digit) begin
						acc_d     = acc_digit;
						too_big_d = too_big_q || acc_ovf;
						seen_d    = 1'b1;
						phase_d   = clen_pkg::PH_DIGITS;
					end else begin
						phase_d = clen_pkg::PH_TAIL;
					end
				end else begin
					priority if (is_digit && digits_ok) begin
						acc_d     = acc_digit;
						too_big_d = too_big_q || acc_ovf;
						seen_d    = 1'b1;
						phase_d   = clen_pkg::PH_DIGITS;
					end else if (is_cr) begin
						phase_d = clen_pkg::PH_TAIL_CR;
					end else begin
						phase_d = clen_pkg::PH_TAIL;
					end
				end
			end
			clen_pkg::PH_BLANK_CR: begin
				if (is_cr) begin
					phase_d = clen_pkg::PH_BLANK_LF;
				end else begin
					phase_d   = clen_pkg::PH_HUNT;
					prefix_d  = '0;
					hunt_d    = '0;
					acc_d     = '0;
					too_big_d = 1'b0;
					neg_d     = 1'b0;
					seen_d    = 1'b0;
					remain_d  = '0;
				end
			end
			clen_pkg::PH_BLANK_LF: begin
				if (is_lf) begin
					phase_d = (remain_q == '0) ? clen_pkg::PH_TRAIL : clen_pkg::PH_BODY;
				end else begin
					phase_d   = clen_pkg::PH_HUNT;
					prefix_d  = '0;
					hunt_d    = '0;
					acc_d     = '0;
					too_big_d = 1'b0;
					neg_d     = 1'b0;
					seen_d    = 1'b0;
					remain_d  = '0;
				end
			end
			clen_pkg::PH_BODY: begin
				remain_d = remain_dec;
				if (remain_dec == '0) begin
					phase_d = clen_pkg::PH_TRAIL;
				end
			end
			clen_pkg::PH_TRAIL: begin
				phase_d   = clen_pkg::PH_HUNT;
				prefix_d  = '0;
				hunt_d    = '0;
				acc_d     = '0;
				too_big_d = 1'b0;
				neg_d     = 1'b0;
				seen_d    = 1'b0;
				remain_d  = '0;
			end
			default: begin
				// hunting for the header prefix
				phase_d = clen_pkg::PH_HUNT;
				if (pfx_done || hunt_fail) begin
					phase_d   = pfx_done ? clen_pkg::PH_LEAD : clen_pkg::PH_HUNT;
					prefix_d  = '0;
					hunt_d    = '0;
					acc_d     = '0;
					too_big_d = 1'b0;
					neg_d     = 1'b0;
					seen_d    = 1'b0;
					remain_d  = '0;
				end else begin
					prefix_d = pfx_hit ? prefix_inc :
					           ((byte_s1 == clen_pkg::CH_C) ? clen_pkg::PFX_W'(1) : '0);
					hunt_d   = hunt_inc;
				end
			end
		endcase
	end

	// result word
	always_comb begin
		result.valid = 1'b0;
		result.kind  = clen_pkg::KIND_BODY;
		result.data  = 8'h00;
		result.code  = clen_pkg::ERR_NONE;
		unique case (phase_q)
			clen_pkg::PH_LEAD_CR, clen_pkg::PH_TAIL_CR: begin
				if (is_lf && len_bad) begin
					result.valid = 1'b1;
					result.kind  = clen_pkg::KIND_ERROR;
					result.code  = clen_pkg::ERR_LENGTH;
				end
			end
			clen_pkg::PH_BLANK_CR: begin
				if (!is_cr) begin
					result.valid = 1'b1;
					result.kind  = clen_pkg::KIND_ERROR;
					result.code  = clen_pkg::ERR_NO_BLANK;
				end
			end
			clen_pkg::PH_BLANK_LF: begin
				if (!is_lf) begin
					result.valid = 1'b1;
					result.kind  = clen_pkg::KIND_ERROR;
					result.code  = clen_pkg::ERR_NO_BLANK;
				end
			end
			clen_pkg::PH_BODY: begin
				result.valid = 1'b1;
				result.data  = byte_s1;
			end
			clen_pkg::PH_TRAIL: begin
				result.valid = 1'b1;
				if (is_lf) begin
					result.kind = clen_pkg::KIND_DONE;
				end else begin
					result.kind = clen_pkg::KIND_ERROR;
					result.code = clen_pkg::ERR_NO_LF;
				end
			end
			clen_pkg::PH_HUNT: begin
				if (hunt_fail) begin
					result.valid = 1'b1;
					result.kind  = clen_pkg::KIND_ERROR;
					result.code  = clen_pkg::ERR_HUNT;
				end
			end
			default: begin
				result.valid = 1'b0;
			end
		endcase
		result.valid = result.valid && step;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= clen_pkg::PH_HUNT;
			prefix_q  <= '0;
			acc_q     <= '0;
			too_big_q <= 1'b0;
			neg_q     <= 1'b0;
			seen_q    <= 1'b0;
			remain_q  <= '0;
			hunt_q    <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			prefix_q  <= prefix_d;
			acc_q     <= acc_d;
			too_big_q <= too_big_d;
			neg_q     <= neg_d;
			seen_q    <= seen_d;
			remain_q  <= remain_d;
			hunt_q    <= hunt_d;
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= clen_pkg::MAX_BODY_RESET;
			max_hunt_q <= clen_pkg::MAX_HUNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (clen_pkg::reg_idx_t'(cfg_index))
				clen_pkg::REG_MAX_BODY: max_body_q <= cfg_data[clen_pkg::MAXLEN_W-1:0];
				clen_pkg::REG_MAX_HUNT: max_hunt_q <= cfg_data[clen_pkg::HUNT_W-1:0];
				default: max_body_q <= max_body_q;
			endcase
		end
	end

endmodule

/* hw/rtl/clen_out_stage.sv */
// ----------------------------------------------------------------------------
// clen_out_stage
// Result register: holds one result word until downstream takes it.
// ----------------------------------------------------------------------------
module clen_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  clen_pkg::result_t result,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        out_kind,
	output logic [7:0]        out_byte,
	output logic [2:0]        error_code
);

	logic              valid_q;
	clen_pkg::result_t word_q;

	// free when empty or emptying this cycle
	assign room = !valid_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= result.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (room && result.valid) begin
			word_q <= result;
		end
	end

	assign out_valid  = valid_q;
	assign out_kind   = word_q.kind;
	assign out_byte   = word_q.data;
	assign error_code = word_q.code;

endmodule

/* hw/rtl/content_length_deframer.sv */
// An accepted byte goes through the input register, then the result register.
// Throughput: one byte per clock while out_stall is low; both registers
// let a new byte in while a finished word still waits downstream.
// Reset: arst_n clears the parser to prefix hunting and loads the limits
// with 2^28 for the body length and 65536 for the hunt bytes.
// ----------------------------------------------------------------------------
// content_length_deframer
// Byte-serial receiver for Content-Length framed messages: drops bytes up to
// the header, reads the length, passes the body through and flags errors.
// ----------------------------------------------------------------------------
module content_length_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [0:0]                 cfg_index,
	input  logic [clen_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 out_kind,
	output logic [7:0]                 out_byte,
	output logic [2:0]                 error_code
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              room;
	logic              advance;
	clen_pkg::result_t result;

	// a word moves into the parser when the result register has room
	assign advance = valid_s1 && room;

	clen_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	clen_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.byte_s1   (byte_s1),
		.result    (result)
	);

	clen_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.result     (result),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.error_code (error_code)
	);

endmodule
